/* src/als_pkg.sv */
// Shared constants for the addressable LED serializer: field widths,
// configuration register indexes and their values after reset. No dependencies.
package als_pkg;

  localparam int unsigned TICK_W   = 16;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned WORD_W   = 3 * COLOR_W;
  localparam int unsigned BIT_IDX_W = 5;
  localparam int unsigned LED_CNT_W = 11;
  localparam int unsigned LED_IDX_W = 10;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(WORD_W - 1);
  localparam logic [LED_CNT_W-1:0] MAX_LEDS = LED_CNT_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ONE_ACTIVE  = 3'd0,
    REG_ONE_IDLE    = 3'd1,
    REG_ZERO_ACTIVE = 3'd2,
    REG_ZERO_IDLE   = 3'd3,
    REG_RESET_TICKS = 3'd4,
    REG_LED_COUNT   = 3'd5,
    REG_INVERT      = 3'd6
  } cfg_reg_t;

  localparam logic [TICK_W-1:0]    RST_ONE_ACTIVE  = 16'd14;
  localparam logic [TICK_W-1:0]    RST_ONE_IDLE    = 16'd0;
  localparam logic [TICK_W-1:0]    RST_ZERO_ACTIVE = 16'd8;
  localparam logic [TICK_W-1:0]    RST_ZERO_IDLE   = 16'd3;
  localparam logic [TICK_W-1:0]    RST_RESET_TICKS = 16'd10;
  localparam logic [LED_CNT_W-1:0] RST_LED_COUNT   = 11'd16;
  localparam logic                 RST_INVERT      = 1'b1;

endpackage

/* src/addressable_led_serializer.sv */
// Addressable LED serializer: one beat in per time-base tick, one beat out.
// Depends on als_pkg for widths, register indexes and reset values.
//
// A result beat is registered and presented in the cycle after its tick beat is accepted.
// Throughput: one tick per cycle; the output register is refilled in the same
// cycle it is drained, so in_stall only rises while a held result is stalled.
// Reset (rst_n low, synchronous): frame engine idle, output register empty,
// configuration registers back to their defaults.
module addressable_led_serializer
  import als_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // tick channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_start_req,
  input  logic [COLOR_W-1:0]    in_green,
  input  logic [COLOR_W-1:0]    in_red,
  input  logic [COLOR_W-1:0]    in_blue,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_pin_level,
  output logic                  out_busy_res,
  output logic                  out_frame_done,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RESET,
    PH_ACTIVE,
    PH_GAP
  } phase_t;

  // configuration registers
  logic [TICK_W-1:0]    one_active_r, one_idle_r, zero_active_r, zero_idle_r;
  logic [TICK_W-1:0]    reset_ticks_r;
  logic [LED_CNT_W-1:0] led_count_r;
  logic                 invert_r;

  // frame engine state
  phase_t               phase_r, phase_nxt;
  logic [TICK_W-1:0]    tick_r, tick_nxt;
  logic [BIT_IDX_W-1:0] bit_r, bit_nxt;
  logic [LED_IDX_W-1:0] led_r, led_nxt;
  logic [WORD_W-1:0]    color_r, color_nxt;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic out_pin_r, out_busy_r, out_done_r;

  logic                 in_fire;
  logic                 active, busy, done, fin;
  logic [TICK_W-1:0]    gap;
  logic [LED_CNT_W-1:0] eff_count;
  logic [LED_CNT_W-1:0] led_inc;

  // Active pulse length for a bit; a zero length stretches to one tick.
  function automatic logic [TICK_W-1:0] act_len(
    input logic              bitv,
    input logic [TICK_W-1:0] one_len,
    input logic [TICK_W-1:0] zero_len
  );
    logic [TICK_W-1:0] a;
    a = bitv ? one_len : zero_len;
    return (a == '0) ? TICK_W'(1) : a;
  endfunction

  // Accept a tick whenever the output register is empty or drains this cycle.
  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  // Clamp the chain length into 1..MAX_LEDS.
  always_comb begin
    if (led_count_r == '0) begin
      eff_count = LED_CNT_W'(1);
    end else if (led_count_r > MAX_LEDS) begin
      eff_count = MAX_LEDS;
    end else begin
      eff_count = led_count_r;
    end
  end

  // One tick of the frame engine. Stages follow the frame order: start latch,
  // leave the reset period, count the active or gap phase, then finish a bit.
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    led_nxt   = led_r;
    color_nxt = color_r;
    active    = 1'b0;
    busy      = 1'b0;
    done      = 1'b0;
    fin       = 1'b0;
    gap       = '0;
    led_inc   = '0;

    // Start: latch the GRB word; the start tick already counts toward reset.
    if (phase_r == PH_IDLE && in_start_req) begin
      color_nxt = {in_green, in_red, in_blue};
      bit_nxt   = '0;
      led_nxt   = '0;
      phase_nxt = PH_RESET;
      tick_nxt  = reset_ticks_r;
    end

    if (phase_nxt != PH_IDLE) begin
      busy = 1'b1;
      // Reset period over (or empty): the first bit begins on this tick.
      if (phase_nxt == PH_RESET && tick_nxt == '0) begin
        phase_nxt = PH_ACTIVE;
        tick_nxt  = act_len(color_nxt[LAST_BIT - bit_nxt], one_active_r, zero_active_r);
      end
      case (phase_nxt)
        PH_RESET: begin
          tick_nxt = tick_nxt - TICK_W'(1);
        end
        PH_ACTIVE: begin
          active   = 1'b1;
          tick_nxt = tick_nxt - TICK_W'(1);
          if (tick_nxt == '0) begin
            gap = color_nxt[LAST_BIT - bit_nxt] ? one_idle_r : zero_idle_r;
            if (gap == '0) begin
              fin = 1'b1;
            end else begin
              phase_nxt = PH_GAP;
              tick_nxt  = gap;
            end
          end
        end
        PH_GAP: begin
          if (tick_nxt != '0) begin
            tick_nxt = tick_nxt - TICK_W'(1);
          end
          if (tick_nxt == '0) begin
            fin = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Finish a bit: advance bit and LED, end the frame or start the next bit.
    if (fin) begin
      if (bit_nxt == LAST_BIT) begin
        bit_nxt = '0;
        led_inc = {1'b0, led_nxt} + LED_CNT_W'(1);
        if (led_inc >= eff_count) begin
          phase_nxt = PH_IDLE;
          tick_nxt  = '0;
          led_nxt   = '0;
          done      = 1'b1;
        end else begin
          led_nxt = led_inc[LED_IDX_W-1:0];
        end
      end else begin
        bit_nxt = bit_nxt + BIT_IDX_W'(1);
      end
      if (!done) begin
        phase_nxt = PH_ACTIVE;
        tick_nxt  = act_len(color_nxt[LAST_BIT - bit_nxt], one_active_r, zero_active_r);
      end
    end
  end

  // Hold a stalled result, load a fresh one on every accepted tick.
  assign out_valid_nxt = in_fire | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_active_r  <= RST_ONE_ACTIVE;
      one_idle_r    <= RST_ONE_IDLE;
      zero_active_r <= RST_ZERO_ACTIVE;
      zero_idle_r   <= RST_ZERO_IDLE;
      reset_ticks_r <= RST_RESET_TICKS;
      led_count_r   <= RST_LED_COUNT;
      invert_r      <= RST_INVERT;
      phase_r       <= PH_IDLE;
      tick_r        <= '0;
      bit_r         <= '0;
      led_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ONE_ACTIVE:  one_active_r  <= cfg_data;
          REG_ONE_IDLE:    one_idle_r    <= cfg_data;
          REG_ZERO_ACTIVE: zero_active_r <= cfg_data;
          REG_ZERO_IDLE:   zero_idle_r   <= cfg_data;
          REG_RESET_TICKS: reset_ticks_r <= cfg_data;
          REG_LED_COUNT:   led_count_r   <= cfg_data[LED_CNT_W-1:0];
          REG_INVERT:      invert_r      <= cfg_data[0];
          default: ;  // drop writes beyond the register list
        endcase
      end
      if (in_fire) begin
        phase_r <= phase_nxt;
        tick_r  <= tick_nxt;
        bit_r   <= bit_nxt;
        led_r   <= led_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
    // payload: no reset needed
    if (in_fire) begin
      color_r    <= color_nxt;
      out_pin_r  <= active ^ invert_r;
      out_busy_r <= busy;
      out_done_r <= done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pin_level  = out_pin_r;
  assign out_busy_res   = out_busy_r;
  assign out_frame_done = out_done_r;

endmodule

/* src/als_checker.sv */
// Port-level checks for addressable_led_serializer, attached by bind.
// Depends only on the port names of the top level.
module als_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_pin_level,
  input logic out_busy_res,
  input logic out_frame_done
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pin_level)
      && $stable(out_busy_res) && $stable(out_frame_done))
    else $error("stalled result beat changed");

  // The tick channel only backs up behind a stalled result.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a stalled result");

  // Every accepted tick yields a result on the next cycle.
  a_one_to_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted tick produced no result");

  // Frame completion is only reported on a busy tick.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_busy_res)
    else $error("frame_done outside a frame");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind addressable_led_serializer als_checker u_als_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_pin_level  (out_pin_level),
  .out_busy_res   (out_busy_res),
  .out_frame_done (out_frame_done)
);
